// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL of the torus point evaluator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk while rst is low.
`define ASSERT_ON_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/tspe_pkg.sv =====
// ----------------------------------------------------------------------------
// Torus point evaluator package
// Word types, register indexes, defaults and the quarter-wave sine generator.
// ----------------------------------------------------------------------------
`default_nettype none

package tspe_pkg;

  localparam int PHASE_BITS_DEF     = 16;
  localparam int SINE_ADDR_BITS_DEF = 10;
  localparam int CFG_INDEX_W        = 4;
  localparam int CFG_DATA_W         = 48;

  localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_X = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Y = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Z = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAJOR_R  = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MINOR_R  = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_X  = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_Y  = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_Z  = 4'd7;

  localparam logic [47:0] FRAME_X_RESET = 48'h0000_0000_4000;
  localparam logic [47:0] FRAME_Y_RESET = 48'h0000_4000_0000;
  localparam logic [47:0] FRAME_Z_RESET = 48'h4000_0000_0000;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef struct packed {
    logic [15:0] u_phase;
    logic [15:0] v_phase;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               saturated;
  } point_t;

  // Sine of a quarter-turn fraction k / 2^abits in Q1.14, by a Taylor series.
  function automatic logic [14:0] quarter_sine(input logic [63:0] k, input int abits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (k * HALF_PI_Q30) >> abits;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
    s  = (x * t) >> 30;
    s  = (s + 64'd32768) >> 16;
    if (s > 64'd16384) begin
      s = 64'd16384;
    end
    return s[14:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/torus_surface_point_eval.sv =====
// ----------------------------------------------------------------------------
// Torus surface point evaluator
// Turns a (u, v) phase word into one saturated Q16.16 point on a torus.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while point_ready is high; each of the eight
// stages holds one word and advances whenever the stage after it is free.
// Reset empties the pipeline and returns the geometry registers to a
// zero-radius torus at the origin with the unit frame.
`default_nettype none

module torus_surface_point_eval #(
  parameter int PHASE_BITS           = tspe_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_ADDR_BITS = tspe_pkg::SINE_ADDR_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          sample_valid,
  output logic                               sample_ready,
  input  wire tspe_pkg::sample_t             sample,
  output logic                               point_valid,
  input  wire logic                          point_ready,
  output tspe_pkg::point_t                   point,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tspe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tspe_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tspe_pkg::*;
`include "assert_macros.svh"

  localparam int A    = SINE_TABLE_ADDR_BITS;
  localparam int W    = A + 2;
  localparam int QTR  = 1 << A;
  localparam int UP1  = (PHASE_BITS >= 16) ? PHASE_BITS - 16 : 0;
  localparam int DN1  = (PHASE_BITS < 16) ? 16 - PHASE_BITS : 0;
  localparam int UP2  = (PHASE_BITS < W) ? W - PHASE_BITS : 0;
  localparam int DN2  = (PHASE_BITS >= W) ? PHASE_BITS - W : 0;
  localparam int NSTG = 8;

  typedef logic [14:0] rom_t [QTR+1];

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k <= QTR; k++) begin
      r[k] = quarter_sine(64'(k), A);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  function automatic logic [W-1:0] wave_addr(input logic [15:0] ph);
    logic [39:0]           e;
    logic [PHASE_BITS-1:0] ps;
    logic [39:0]           f;
    e  = (40'(ph) << UP1) >> DN1;
    ps = e[PHASE_BITS-1:0];
    f  = (40'(ps) << UP2) >> DN2;
    return f[W-1:0];
  endfunction

  function automatic logic signed [15:0] wave_sine(input logic [W-1:0] addr);
    logic [A:0]  eff;
    logic [14:0] mag;
    if (addr[A]) begin
      eff = (A+1)'(QTR) - {1'b0, addr[A-1:0]};
    end else begin
      eff = {1'b0, addr[A-1:0]};
    end
    mag = SINE_ROM[eff];
    if (addr[A+1]) begin
      return -$signed({1'b0, mag});
    end
    return $signed({1'b0, mag});
  endfunction

  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic [30:0]        major_radius;
  logic [30:0]        minor_radius;
  logic [47:0]        frame_x_axis;
  logic [47:0]        frame_y_axis;
  logic [47:0]        frame_z_axis;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      origin_z     <= '0;
      major_radius <= '0;
      minor_radius <= '0;
      frame_x_axis <= FRAME_X_RESET;
      frame_y_axis <= FRAME_Y_RESET;
      frame_z_axis <= FRAME_Z_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ORIGIN_X: origin_x     <= $signed(cfg_data[31:0]);
        CFG_ORIGIN_Y: origin_y     <= $signed(cfg_data[31:0]);
        CFG_ORIGIN_Z: origin_z     <= $signed(cfg_data[31:0]);
        CFG_MAJOR_R:  major_radius <= cfg_data[30:0];
        CFG_MINOR_R:  minor_radius <= cfg_data[30:0];
        CFG_FRAME_X:  frame_x_axis <= cfg_data;
        CFG_FRAME_Y:  frame_y_axis <= cfg_data;
        CFG_FRAME_Z:  frame_z_axis <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage valid bits and per-stage advance.
  logic [NSTG:1] vld;
  logic [NSTG:1] adv;

  always_comb begin
    adv[NSTG] = !vld[NSTG] || point_ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign sample_ready = adv[1];
  assign point_valid  = vld[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= sample_valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 1: wave addresses and table lookup.
  logic [W-1:0]       ua;
  logic [W-1:0]       va;
  logic signed [15:0] su1, cu1, sv1, cv1;

  assign ua = wave_addr(sample.u_phase);
  assign va = wave_addr(sample.v_phase);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      su1 <= wave_sine(ua);
      cu1 <= wave_sine(ua + W'(QTR));
      sv1 <= wave_sine(va);
      cv1 <= wave_sine(va + W'(QTR));
    end
  end

  // Stage 2: minor radius times the tube sine and cosine.
  logic signed [47:0] prc2, prs2;
  logic signed [15:0] sv2, cv2;
  logic signed [31:0] r_s;

  assign r_s = $signed({1'b0, minor_radius});

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      prc2 <= r_s * cu1;
      prs2 <= r_s * su1;
      sv2  <= sv1;
      cv2  <= cv1;
    end
  end

  // Stage 3: round, form the sweep radius rho and the height h.
  logic signed [47:0] rc_r, rs_r;
  logic signed [33:0] rho3, h3;
  logic signed [15:0] sv3, cv3;

  assign rc_r = prc2 + 48'sd8192;
  assign rs_r = prs2 + 48'sd8192;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      rho3 <= $signed({3'b000, major_radius}) + $signed(rc_r[47:14]);
      h3   <= $signed(rs_r[47:14]);
      sv3  <= sv2;
      cv3  <= cv2;
    end
  end

  // Stage 4: rho times the sweep cosine and sine.
  logic signed [49:0] pa4, pb4;
  logic signed [33:0] h4;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      pa4 <= rho3 * cv3;
      pb4 <= rho3 * sv3;
      h4  <= h3;
    end
  end

  // Stage 5: round to the in-plane coordinates a and b.
  logic signed [49:0] ra, rb;
  logic signed [33:0] a5, b5, h5;

  assign ra = pa4 + 50'sd8192;
  assign rb = pb4 + 50'sd8192;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      a5 <= $signed(ra[47:14]);
      b5 <= $signed(rb[47:14]);
      h5 <= h4;
    end
  end

  // Stage 6: project onto the frame, one product per axis and component.
  logic signed [15:0] fx [3];
  logic signed [15:0] fy [3];
  logic signed [15:0] fz [3];
  logic signed [49:0] tx6 [3];
  logic signed [49:0] ty6 [3];
  logic signed [49:0] tz6 [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      fx[c] = $signed(frame_x_axis[16*c +: 16]);
      fy[c] = $signed(frame_y_axis[16*c +: 16]);
      fz[c] = $signed(frame_z_axis[16*c +: 16]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      for (int c = 0; c < 3; c++) begin
        tx6[c] <= a5 * fx[c];
        ty6[c] <= b5 * fy[c];
        tz6[c] <= h5 * fz[c];
      end
    end
  end

  // Stage 7: combine the three projections.
  logic signed [51:0] acc7 [3];

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      for (int c = 0; c < 3; c++) begin
        acc7[c] <= 52'(tx6[c]) - 52'(ty6[c]) + 52'(tz6[c]);
      end
    end
  end

  // Stage 8: round, add the origin and saturate.
  logic signed [31:0] org [3];
  logic signed [51:0] accr [3];
  logic signed [38:0] pos [3];
  logic signed [31:0] clip [3];
  logic [2:0]         clipped;

  assign org[0] = origin_x;
  assign org[1] = origin_y;
  assign org[2] = origin_z;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      accr[c] = acc7[c] + 52'sd8192;
      pos[c]  = 39'(org[c]) + $signed(accr[c][51:14]);
      if (pos[c] > 39'sd2147483647) begin
        clip[c]    = 32'sh7FFF_FFFF;
        clipped[c] = 1'b1;
      end else if (pos[c] < -39'sd2147483648) begin
        clip[c]    = 32'sh8000_0000;
        clipped[c] = 1'b1;
      end else begin
        clip[c]    = pos[c][31:0];
        clipped[c] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      point.point_x   <= clip[0];
      point.point_y   <= clip[1];
      point.point_z   <= clip[2];
      point.saturated <= |clipped;
    end
  end

  `ASSERT_ON_CLK(a_accept_fills_stage1, sample_valid && sample_ready |=> vld[1],
                 "accepted word did not reach the first stage")
  `ASSERT_ON_CLK(a_ready_only_when_full, !sample_ready |-> vld[1] && vld[NSTG],
                 "input stalled with a free pipeline")
  `ASSERT_ON_CLK(a_sat_at_limit, point_valid && point.saturated |->
                 point.point_x == 32'sh7FFF_FFFF || point.point_x == 32'sh8000_0000 ||
                 point.point_y == 32'sh7FFF_FFFF || point.point_y == 32'sh8000_0000 ||
                 point.point_z == 32'sh7FFF_FFFF || point.point_z == 32'sh8000_0000,
                 "saturated flag set with no coordinate at a limit")

endmodule

`default_nettype wire
